// File: rtl/afl_pkg.sv
// Shared types and constants for the animation frame lookup block.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package afl_pkg;

  // Opcodes carried in the input tuser field.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_NEXT  = 2'd2;

  // Configuration register indexes.
  localparam int          CFG_IDX_W        = 2;
  localparam logic [1:0]  CFG_PLAY_MODE    = 2'd0;
  localparam logic [1:0]  CFG_FRAME_COUNT  = 2'd1;
  localparam logic [1:0]  CFG_ACTION_LEN   = 2'd2;

  // Field widths.
  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int TIME_W  = 32;
  localparam int FC_W    = 7;
  localparam int FRES_W  = 6;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 8;

  // Reset values of the configuration registers.
  localparam logic             PLAY_MODE_RST   = 1'b0;
  localparam logic [FC_W-1:0]  FRAME_COUNT_RST = 7'd1;
  localparam logic [TIME_W-1:0] ACTION_LEN_RST = 32'h0001_0000;

  // Remainder unit: one quotient bit per cycle.
  localparam int DIV_STEPS = TIME_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MOD,
    S_HINT_RD,
    S_HINT_CMP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_NEXT
  } state_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_LAST,
    RES_LIM,
    RES_HIT,
    RES_NEXT
  } res_sel_t;

  typedef struct packed {
    logic     mem_wr;
    logic     load;
    logic     div_init;
    logic     div_step;
    logic     rd_hint;
    logic     rd_scan;
    logic     scan_init_back;
    logic     scan_init_fwd;
    logic     scan_adv;
    logic     out_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic play_loop;
    logic len_zero;
    logic t_ge_len;
    logic div_last;
    logic hint_zero;
    logic data_gt;
    logic scan_end;
  } status_t;

endpackage

// File: rtl/afl_ctrl.sv
// Controller state machine for the animation frame lookup block.
// Sequences writes, the remainder unit, the table scan and the result register.
// Depends on afl_pkg.
module afl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [1:0]        in_op,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  input  afl_pkg::status_t  st,
  output afl_pkg::cmd_t     cmd
);
  import afl_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_fire   = in_tvalid && (state_r == S_IDLE);
    out_free  = !out_valid_r || out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_WRITE: cmd.mem_wr = 1'b1;
            OP_GET: begin
              cmd.load  = 1'b1;
              state_nxt = S_CHECK;
            end
            OP_NEXT: begin
              cmd.load  = 1'b1;
              state_nxt = S_NEXT;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        // One-shot mode: a time at or past the action length gives the last frame.
        if (!st.play_loop && st.t_ge_len) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            cmd.res_sel  = RES_LAST;
            state_nxt    = S_IDLE;
          end
        end else if (st.play_loop && !st.len_zero) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_MOD;
        end else begin
          state_nxt = S_HINT_RD;
        end
      end
      S_MOD: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_HINT_RD;
        end
      end
      S_HINT_RD: begin
        cmd.rd_hint = 1'b1;
        state_nxt   = S_HINT_CMP;
      end
      S_HINT_CMP: begin
        if (st.data_gt) begin
          if (st.hint_zero) begin
            if (out_free) begin
              cmd.out_load = 1'b1;
              cmd.res_sel  = RES_ZERO;
              state_nxt    = S_IDLE;
            end
          end else begin
            cmd.scan_init_back = 1'b1;
            state_nxt          = S_SCAN_RD;
          end
        end else begin
          cmd.scan_init_fwd = 1'b1;
          state_nxt         = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (st.scan_end) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            cmd.res_sel  = RES_LIM;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (st.data_gt) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            cmd.res_sel  = RES_HIT;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_NEXT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.res_sel  = RES_NEXT;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// File: rtl/afl_dpath.sv
// Datapath for the animation frame lookup block: configuration registers,
// start time table, bit-serial remainder unit, scan pointers and result register.
// Depends on afl_pkg; driven by afl_ctrl.
module afl_dpath #(
  parameter int MAX_FRAMES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  afl_pkg::cmd_t                 cmd,
  output afl_pkg::status_t              st,
  input  logic [afl_pkg::IDX_W-1:0]     in_frame_index,
  input  logic [afl_pkg::TIME_W-1:0]    in_time_value,
  input  logic                          cfg_valid,
  input  logic [afl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afl_pkg::TIME_W-1:0]    cfg_data,
  output logic [afl_pkg::FRES_W-1:0]    out_frame_result
);
  import afl_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);
  // Wide enough for the frame count register, an input index and MAX_FRAMES itself.
  localparam int NW = ($clog2(MAX_FRAMES + 1) > FC_W) ? $clog2(MAX_FRAMES + 1) : FC_W;

  logic              play_mode_r;
  logic [FC_W-1:0]   frame_count_r;
  logic [TIME_W-1:0] action_len_r;

  logic [TIME_W-1:0] mem [MAX_FRAMES];
  logic [TIME_W-1:0] rdata_r;

  logic [NW-1:0]     hint_r;
  logic [NW-1:0]     j_r;
  logic [NW-1:0]     lim_r;
  logic [TIME_W-1:0] t_r;
  logic [TIME_W-1:0] rem_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [FRES_W-1:0] out_data_r;

  logic [NW-1:0]     n_w;
  logic [NW-1:0]     fc_w;
  logic [NW-1:0]     idx_w;
  logic [NW-1:0]     nxt1_w;
  logic [NW-1:0]     res_w;
  logic [TIME_W:0]   div_tmp;
  logic [TIME_W+1:0] div_diff;
  logic [TIME_W-1:0] rem_nxt;
  logic [AW-1:0]     rd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_mode_r   <= PLAY_MODE_RST;
      frame_count_r <= FRAME_COUNT_RST;
      action_len_r  <= ACTION_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PLAY_MODE:   play_mode_r   <= cfg_data[0];
        CFG_FRAME_COUNT: frame_count_r <= cfg_data[FC_W-1:0];
        CFG_ACTION_LEN:  action_len_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frames in use: zero acts as one, anything above the table depth as the depth.
  always_comb begin
    fc_w  = NW'(frame_count_r);
    idx_w = NW'(in_frame_index);
    if (fc_w == '0) begin
      n_w = NW'(1);
    end else if (fc_w > NW'(MAX_FRAMES)) begin
      n_w = NW'(MAX_FRAMES);
    end else begin
      n_w = fc_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && (idx_w < NW'(MAX_FRAMES))) begin
      mem[idx_w[AW-1:0]] <= in_time_value;
    end
  end

  assign rd_addr = cmd.rd_hint ? hint_r[AW-1:0] : j_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd_hint || cmd.rd_scan) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Restoring remainder step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    div_tmp  = {rem_r, t_r[TIME_W-1]};
    div_diff = {1'b0, div_tmp} - {2'b00, action_len_r};
    rem_nxt  = div_diff[TIME_W+1] ? div_tmp[TIME_W-1:0] : div_diff[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r    <= in_time_value;
      hint_r <= (idx_w >= n_w) ? (n_w - NW'(1)) : idx_w;
    end else if (cmd.div_step) begin
      // The dividend shifts out; after the last step the remainder takes its place.
      t_r <= (cnt_r == DIV_CW'(DIV_STEPS - 1)) ? rem_nxt : {t_r[TIME_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + DIV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init_back) begin
      j_r   <= NW'(1);
      lim_r <= hint_r;
    end else if (cmd.scan_init_fwd) begin
      j_r   <= hint_r + NW'(1);
      lim_r <= n_w;
    end else if (cmd.scan_adv) begin
      j_r <= j_r + NW'(1);
    end
  end

  assign nxt1_w = hint_r + NW'(1);

  always_comb begin
    case (cmd.res_sel)
      RES_ZERO: res_w = '0;
      RES_LAST: res_w = n_w - NW'(1);
      RES_LIM:  res_w = lim_r - NW'(1);
      RES_HIT:  res_w = j_r - NW'(1);
      RES_NEXT: begin
        if (play_mode_r) begin
          res_w = (nxt1_w == n_w) ? '0 : nxt1_w;
        end else begin
          res_w = (nxt1_w < n_w) ? nxt1_w : (n_w - NW'(1));
        end
      end
      default: res_w = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res_w[FRES_W-1:0];
    end
  end

  assign out_frame_result = out_data_r;

  assign st.play_loop = play_mode_r;
  assign st.len_zero  = (action_len_r == '0);
  assign st.t_ge_len  = (t_r >= action_len_r);
  assign st.div_last  = (cnt_r == DIV_CW'(DIV_STEPS - 1));
  assign st.hint_zero = (hint_r == '0);
  assign st.data_gt   = (rdata_r > t_r);
  assign st.scan_end  = (j_r >= lim_r);

endmodule

// File: rtl/animation_frame_lookup.sv
// Top level of the animation frame lookup block.
// Joins the controller (afl_ctrl) and the datapath (afl_dpath); uses afl_pkg.
//
//   Channel   Direction  Handshake          Payload
//   in_       slave      in_tvalid/tready   tuser[1:0] op; tdata frame_index, time_value
//   out_      master     out_tvalid/tready  tdata frame_result
//   cfg_      slave      cfg_valid/ready    cfg_index register, cfg_data value
//
// Write: done in idle. Next frame: via S_NEXT. Get frame: S_CHECK, a hint read and
// compare, then a scan of one table entry per read (one read port); loop mode with a
// nonzero action length adds the bit-serial remainder, and a one-shot time at or
// past the action length gives the last frame. Reset is synchronous, active low, and
// clears the control state and configuration registers, not the table. A stalled
// output holds the next item in its final state; config never stalls.
module animation_frame_lookup #(
  parameter int MAX_FRAMES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [afl_pkg::IN_DW-1:0]     in_tdata,   // [5:0] frame_index, [37:6] time_value
  input  logic [afl_pkg::OP_W-1:0]      in_tuser,   // [1:0] op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [afl_pkg::OUT_DW-1:0]    out_tdata,  // [5:0] frame_result
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [afl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afl_pkg::TIME_W-1:0]    cfg_data
);
  import afl_pkg::*;

  cmd_t              cmd;
  status_t           st;
  logic [FRES_W-1:0] frame_result;

  afl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .st         (st),
    .cmd        (cmd)
  );

  afl_dpath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_frame_index   (in_tdata[IDX_W-1:0]),
    .in_time_value    (in_tdata[IDX_W+TIME_W-1:IDX_W]),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_frame_result (frame_result)
  );

  assign cfg_ready = 1'b1;
  assign out_tdata = {{(OUT_DW-FRES_W){1'b0}}, frame_result};

endmodule

// File: rtl/afl_checker.sv
// Port-level checker for the animation frame lookup block, bound to the top level.
// Depends on afl_pkg.
module afl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [afl_pkg::OP_W-1:0]      in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [afl_pkg::OUT_DW-1:0]    out_tdata
);
  import afl_pkg::*;

  // A result waiting on the output keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  // Queries occupy the block, so it cannot take another item on the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_GET || in_tuser == OP_NEXT) |=> !in_tready)
    else $error("block ready right after accepting a query");

  // Table writes finish in the cycle they are accepted.
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_WRITE |=> in_tready)
    else $error("block busy after a table write");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind animation_frame_lookup afl_checker u_afl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/sv/tb_animation_frame_lookup.sv
// Self-checking testbench for animation_frame_lookup: a directed table, then random phases.
// Results are predicted by an independent frame search model, or typed in for directed rows, and checked in order.
// Depends on afl_pkg and the animation_frame_lookup RTL.
`timescale 1ns / 100ps

module tb_animation_frame_lookup;
  import afl_pkg::*;

  localparam int MAX_FRAMES   = 64;
  localparam int RANDOM_ITEMS = 620;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam logic MODE_ONESHOT = 1'b0;
  localparam logic MODE_LOOP    = 1'b1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One directed step: an input item, or a register write when kind is ROW_CFG.
  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         code;
    logic [IDX_W-1:0]   idx;
    logic [TIME_W-1:0]  value;
    logic               typed;
    logic [FRES_W-1:0]  want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DW-1:0]      in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DW-1:0]     out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [TIME_W-1:0]     cfg_data   = '0;

  // Typed-in expectation travelling with the item on offer.
  logic                  item_typed = 1'b0;
  logic [FRES_W-1:0]     item_want  = '0;

  // Frame search model state.
  logic                  model_mode;
  logic [FC_W-1:0]       model_count;
  logic [TIME_W-1:0]     model_len;
  logic [TIME_W-1:0]     start_table [MAX_FRAMES];
  logic [FRES_W-1:0]     pending_frames [$];

  logic [TIME_W-1:0]     loaded_times [MAX_FRAMES];
  dir_row_t              dir_rows [33];
  int unsigned           fault_count  = 0;
  int unsigned           cycle_count  = 0;
  int unsigned           random_sent  = 0;
  bit                    tx_calm      = 1'b0;
  bit                    rx_calm      = 1'b0;
  bit                    hold_req     = 1'b0;

  animation_frame_lookup #(.MAX_FRAMES(MAX_FRAMES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Linear search from the hint; a backward search that finds nothing gives hint - 1.
  function automatic logic [FRES_W-1:0] seek_frame(input logic [TIME_W-1:0] t,
                                                   input int unsigned hint,
                                                   input int unsigned n);
    int unsigned h;
    h = (hint >= n) ? n - 1 : hint;
    if (start_table[h] > t) begin
      if (h == 0) return '0;
      for (int unsigned i = 0; i + 1 < h; i++)
        if (start_table[i + 1] > t) return FRES_W'(i);
      return FRES_W'(h - 1);
    end
    for (int unsigned i = h; i + 1 < n; i++)
      if (start_table[i + 1] > t) return FRES_W'(i);
    return FRES_W'(n - 1);
  endfunction

  function automatic bit frame_for_item(input logic [OP_W-1:0] op,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [TIME_W-1:0] t,
                                        output logic [FRES_W-1:0] frame);
    int unsigned n, f;
    logic [TIME_W-1:0] tq;
    bit has_result;
    n = (model_count == 0) ? 1 : (model_count > MAX_FRAMES) ? MAX_FRAMES : model_count;
    frame = '0;
    has_result = 1'b1;
    case (op)
      OP_GET: begin
        if (model_mode == MODE_ONESHOT && t >= model_len) begin
          frame = FRES_W'(n - 1);
        end else begin
          tq = (model_mode == MODE_LOOP && model_len != 0) ? t % model_len : t;
          frame = seek_frame(tq, idx, n);
        end
      end
      OP_NEXT: begin
        f = (idx >= n) ? n - 1 : idx;
        if (model_mode == MODE_ONESHOT) frame = FRES_W'((f + 1 < n) ? f + 1 : n - 1);
        else frame = FRES_W'((f + 1) % n);
      end
      default: has_result = 1'b0;
    endcase
    return has_result;
  endfunction

  // Tracks accepted items and register writes, and checks every result in order.
  always @(posedge clk) begin : scoreboard
    logic [FRES_W-1:0] frame;
    logic [FRES_W-1:0] want;
    if (!rst_n) begin
      model_mode  = PLAY_MODE_RST;
      model_count = FRAME_COUNT_RST;
      model_len   = ACTION_LEN_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_frames.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("unexpected result: frame %0d", out_tdata[FRES_W-1:0]);
        end else begin
          want = pending_frames.pop_front();
          if (out_tdata[FRES_W-1:0] !== want) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display("frame_result mismatch: expected %0d, got %0d", want,
                       out_tdata[FRES_W-1:0]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_WRITE)
          start_table[in_tdata[IDX_W-1:0]] = in_tdata[IDX_W +: TIME_W];
        else if (frame_for_item(in_tuser, in_tdata[IDX_W-1:0], in_tdata[IDX_W +: TIME_W],
                                frame))
          pending_frames.push_back(item_typed ? item_want : frame);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PLAY_MODE:   model_mode  = cfg_data[0];
          CFG_FRAME_COUNT: model_count = cfg_data[FC_W-1:0];
          CFG_ACTION_LEN:  model_len   = cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, calm stretches, and one long hold-off on request.
  initial begin : receiver
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [TIME_W-1:0] t, input logic typed,
                           input logic [FRES_W-1:0] want, input bit burst);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    gap = (burst || tx_calm) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= op;
    in_tdata   <= {2'b00, t, idx};
    item_typed <= typed;
    item_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op != OP_NONE) random_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx, input logic [TIME_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected frame has come back, then lets write items settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One random phase: new settings, a fresh ascending table, then mixed queries.
  task automatic run_phase(input bit pressure);
    int unsigned pick, n_eff, k, stepmax, nq, j;
    logic [FC_W-1:0]   fc;
    logic [TIME_W-1:0] len, t, top;
    logic [63:0]       acc, top64;
    logic [IDX_W-1:0]  idx;
    logic [OP_W-1:0]   op;
    drain();
    pick = $urandom_range(0, 15);
    if (pick == 0) fc = FC_W'(0);
    else if (pick == 1) fc = FC_W'($urandom_range(65, 127));
    else if (pick <= 3) fc = FC_W'(64);
    else if (pick <= 5) fc = FC_W'($urandom_range(17, 63));
    else fc = FC_W'($urandom_range(1, 16));
    n_eff = (fc == 0) ? 1 : (fc > MAX_FRAMES) ? MAX_FRAMES : fc;
    k = $urandom_range(0, 25);
    stepmax = 1 << k;
    acc = 64'($urandom_range(0, stepmax));
    for (j = 0; j < n_eff; j++) begin
      loaded_times[j] = acc[TIME_W-1:0];
      if ($urandom_range(0, 7) != 0) acc += 64'($urandom_range(1, stepmax));
    end
    pick = $urandom_range(0, 15);
    if (pick == 0) len = '0;
    else if (pick == 1) len = '1;
    else if (pick == 2) len = $urandom;
    else if (pick == 3) len = 32'd1;
    else len = loaded_times[n_eff - 1] + $urandom_range(1, stepmax);
    write_reg(CFG_PLAY_MODE, {31'd0, 1'($urandom_range(0, 1))});
    write_reg(CFG_FRAME_COUNT, {25'd0, fc});
    write_reg(CFG_ACTION_LEN, len);
    for (j = 0; j < n_eff; j++) send_item(OP_WRITE, IDX_W'(j), loaded_times[j], 1'b0, '0, 1'b0);
    top64 = (len == 0) ? 64'(loaded_times[n_eff - 1]) + stepmax : 64'(len) * 3;
    top = (top64 > 64'hFFFF_FFFF) ? '1 : top64[TIME_W-1:0];
    nq = pressure ? 20 : $urandom_range(30, 60);
    if (pressure) hold_req = 1'b1;
    for (int unsigned q = 0; q < nq; q++) begin
      pick = $urandom_range(0, 99);
      op = pressure ? OP_GET : (pick < 60) ? OP_GET : (pick < 85) ? OP_NEXT :
           (pick < 93) ? OP_WRITE : OP_NONE;
      idx = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 63))
                                 : IDX_W'($urandom_range(0, n_eff - 1));
      j = $urandom_range(0, n_eff - 1);
      pick = $urandom_range(0, 7);
      if (op == OP_WRITE || op == OP_NONE || pick == 0) t = $urandom;
      else if (pick == 1) t = loaded_times[j];
      else if (pick == 2) t = loaded_times[j] - 1;
      else t = $urandom_range(0, top);
      // Stray writes may break the ascending order on purpose.
      if (op == OP_WRITE) loaded_times[idx] = t;
      send_item(op, idx, t, 1'b0, '0, pressure);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_no;
    dir_rows = '{
      '{ROW_ITEM, OP_NEXT,  6'd0,  32'h0000_0000, 1'b1, 6'd0},
      '{ROW_ITEM, OP_NEXT,  6'd63, 32'hFFFF_FFFF, 1'b1, 6'd0},
      '{ROW_ITEM, OP_GET,   6'd0,  32'hFFFF_FFFF, 1'b1, 6'd0},
      '{ROW_ITEM, OP_GET,   6'd63, 32'h0000_8000, 1'b1, 6'd0},
      '{ROW_CFG,  CFG_FRAME_COUNT, 6'd0, 32'd64, 1'b0, 6'd0},
      '{ROW_CFG,  CFG_ACTION_LEN,  6'd0, 32'hFFFF_FFFF, 1'b0, 6'd0},
      '{ROW_ITEM, OP_GET,   6'd0,  32'h0000_0000, 1'b1, 6'd0},
      '{ROW_ITEM, OP_GET,   6'd0,  32'h0003_F000, 1'b1, 6'd63},
      // Backward search with nothing found before the hint.
      '{ROW_ITEM, OP_GET,   6'd20, 32'h0001_3800, 1'b0, 6'd0},
      '{ROW_ITEM, OP_GET,   6'd32, 32'h0002_0800, 1'b0, 6'd0},
      '{ROW_ITEM, OP_NEXT,  6'd62, 32'h0000_0000, 1'b1, 6'd63},
      '{ROW_ITEM, OP_NEXT,  6'd63, 32'h0000_0000, 1'b1, 6'd63},
      '{ROW_ITEM, OP_WRITE, 6'd63, 32'hFFFF_FFFF, 1'b0, 6'd0},
      '{ROW_ITEM, OP_GET,   6'd62, 32'hFFFF_FFFE, 1'b0, 6'd0},
      '{ROW_ITEM, OP_WRITE, 6'd0,  32'h0000_0100, 1'b0, 6'd0},
      // Hint zero with a time before the first frame.
      '{ROW_ITEM, OP_GET,   6'd0,  32'h0000_0080, 1'b1, 6'd0},
      '{ROW_ITEM, OP_NONE,  6'd63, 32'hFFFF_FFFF, 1'b0, 6'd0},
      '{ROW_CFG,  CFG_ACTION_LEN,  6'd0, 32'h0000_0000, 1'b0, 6'd0},
      '{ROW_ITEM, OP_GET,   6'd5,  32'h0000_0000, 1'b1, 6'd63},
      '{ROW_CFG,  CFG_PLAY_MODE,   6'd0, 32'(MODE_LOOP), 1'b0, 6'd0},
      '{ROW_ITEM, OP_GET,   6'd7,  32'h0002_0800, 1'b0, 6'd0},
      '{ROW_ITEM, OP_NEXT,  6'd63, 32'h0000_0000, 1'b1, 6'd0},
      '{ROW_CFG,  CFG_ACTION_LEN,  6'd0, 32'h0004_0000, 1'b0, 6'd0},
      '{ROW_ITEM, OP_GET,   6'd40, 32'hFFFF_FFFF, 1'b0, 6'd0},
      '{ROW_CFG,  CFG_FRAME_COUNT, 6'd0, 32'd0, 1'b0, 6'd0},
      '{ROW_ITEM, OP_NEXT,  6'd0,  32'h0000_0000, 1'b1, 6'd0},
      '{ROW_CFG,  CFG_FRAME_COUNT, 6'd0, 32'd127, 1'b0, 6'd0},
      '{ROW_ITEM, OP_NEXT,  6'd63, 32'h0000_0000, 1'b1, 6'd0},
      '{ROW_CFG,  CFG_FRAME_COUNT, 6'd0, 32'd10, 1'b0, 6'd0},
      '{ROW_ITEM, OP_NEXT,  6'd40, 32'h0000_0000, 1'b1, 6'd0},
      '{ROW_CFG,  CFG_PLAY_MODE,   6'd0, 32'(MODE_ONESHOT), 1'b0, 6'd0},
      '{ROW_ITEM, OP_NEXT,  6'd40, 32'h0000_0000, 1'b1, 6'd9},
      '{ROW_ITEM, OP_GET,   6'd50, 32'h0000_0000, 1'b0, 6'd0}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The table is not cleared by reset, so every entry gets a start time first.
    for (int unsigned i = 0; i < MAX_FRAMES; i++)
      send_item(OP_WRITE, IDX_W'(i), TIME_W'(i) << 12, 1'b0, '0, 1'b0);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[r].code, dir_rows[r].value);
      end else begin
        send_item(dir_rows[r].code, dir_rows[r].idx, dir_rows[r].value,
                  dir_rows[r].typed, dir_rows[r].want, 1'b0);
      end
    end

    random_sent = 0;
    phase_no = 0;
    while (random_sent < RANDOM_ITEMS) begin
      run_phase(phase_no == 3);
      phase_no++;
    end

    drain();
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
